>>> hdl/pqs_pkg.sv
// Package: shared constants, codes and controller/datapath structs for the scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pqs_pkg;
  localparam int CRIT_DEPTH  = 16;
  localparam int HIGH_DEPTH  = 16;
  localparam int NORM_DEPTH  = 32;
  localparam int ALERT_MAX_LEN = 128;
  localparam int AUDIO_MAX_LEN = 512;
  localparam logic [31:0] WINDOW_MS = 32'd1000;

  localparam int CRIT_AW = $clog2(CRIT_DEPTH);
  localparam int HIGH_AW = $clog2(HIGH_DEPTH);
  localparam int NORM_AW = $clog2(NORM_DEPTH);

  // command codes
  localparam logic [2:0] CMD_ENQ_CRIT = 3'd0;
  localparam logic [2:0] CMD_ENQ_HIGH = 3'd1;
  localparam logic [2:0] CMD_ENQ_AUD  = 3'd2;
  localparam logic [2:0] CMD_DEQ      = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_RATE    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // class codes
  localparam logic [1:0] CLS_CRIT = 2'd0;
  localparam logic [1:0] CLS_HIGH = 2'd1;
  localparam logic [1:0] CLS_NORM = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_CRIT_CAP = 3'd1;
  localparam logic [2:0] REG_HIGH_CAP = 3'd2;
  localparam logic [2:0] REG_NORM_CAP = 3'd3;
  localparam logic [2:0] REG_RATE     = 3'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic       latch;     // capture input word
    logic       exec;      // apply the captured command
  } pqs_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       done;      // result registers loaded
  } pqs_stat_t;
endpackage
`default_nettype wire

>>> hdl/priority_queue_scheduler_rate_limited_top.sv
// Top level: strict priority descriptor scheduler with audio rate limiter.
//   channel | handshake              | ports
//   in      | start & !busy          | in_command, in_now_ms, in_payload_ref, in_payload_length
//   out     | out_valid (one cycle)  | out_status ... out_audio_sent_in_window
//   cfg     | cfg_we                 | cfg_index, cfg_data
// Each command runs capture (the accepting cycle), head read from
// the store memories, commit and result strobe in turn. busy is high from head read
// through result strobe, so no new word is taken until a command is done.
// Synchronous active-low reset; stores are not cleared. The result receiver
// cannot stall; each result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module priority_queue_scheduler_rate_limited_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [15:0] in_payload_ref,
  input  wire logic [9:0]  in_payload_length,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [1:0]       out_class,
  output logic [31:0]      out_timestamp,
  output logic [15:0]      out_payload_ref,
  output logic [9:0]       out_length,
  output logic [4:0]       out_critical_count,
  output logic [4:0]       out_high_count,
  output logic [5:0]       out_normal_count,
  output logic [15:0]      out_dropped_critical,
  output logic [15:0]      out_dropped_high,
  output logic [15:0]      out_dropped_normal,
  output logic [15:0]      out_audio_sent_in_window
);
  pqs_pkg::pqs_cmd_t  cmd;
  pqs_pkg::pqs_stat_t stat;

  pqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .stat(stat)
  );

  pqs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_command(in_command), .in_now_ms(in_now_ms),
    .in_payload_ref(in_payload_ref), .in_payload_length(in_payload_length),
    .out_status(out_status), .out_class(out_class), .out_timestamp(out_timestamp),
    .out_payload_ref(out_payload_ref), .out_length(out_length),
    .out_critical_count(out_critical_count), .out_high_count(out_high_count),
    .out_normal_count(out_normal_count), .out_dropped_critical(out_dropped_critical),
    .out_dropped_high(out_dropped_high), .out_dropped_normal(out_dropped_normal),
    .out_audio_sent_in_window(out_audio_sent_in_window)
  );
endmodule
`default_nettype wire

>>> hdl/pqs_ctrl.sv
// Controller: sequences capture, execute and result strobe per command.
`timescale 1ns / 1ps
`default_nettype none
module pqs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output pqs_pkg::pqs_cmd_t      cmd,
  input  wire pqs_pkg::pqs_stat_t stat
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: if (stat.done) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.latch = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);
endmodule
`default_nettype wire

>>> hdl/pqs_dp.sv
// Datapath: FIFO stores, pointers, rate window, drop counters and result registers.
`timescale 1ns / 1ps
`default_nettype none
module pqs_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pqs_pkg::pqs_cmd_t  cmd,
  output pqs_pkg::pqs_stat_t      stat,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [2:0]         in_command,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic [15:0]        in_payload_ref,
  input  wire logic [9:0]         in_payload_length,
  output logic [2:0]              out_status,
  output logic [1:0]              out_class,
  output logic [31:0]             out_timestamp,
  output logic [15:0]             out_payload_ref,
  output logic [9:0]              out_length,
  output logic [4:0]              out_critical_count,
  output logic [4:0]              out_high_count,
  output logic [5:0]              out_normal_count,
  output logic [15:0]             out_dropped_critical,
  output logic [15:0]             out_dropped_high,
  output logic [15:0]             out_dropped_normal,
  output logic [15:0]             out_audio_sent_in_window
);
  localparam int CAW = pqs_pkg::CRIT_AW;
  localparam int HAW = pqs_pkg::HIGH_AW;
  localparam int NAW = pqs_pkg::NORM_AW;

  // configuration
  logic        en_r;
  logic [4:0]  ccap_r, hcap_r;
  logic [5:0]  ncap_r;
  logic [15:0] rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0; ccap_r <= 5'd10; hcap_r <= 5'd10; ncap_r <= 6'd20; rate_r <= 16'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        pqs_pkg::REG_ENABLE:   en_r   <= cfg_data[0];
        pqs_pkg::REG_CRIT_CAP: ccap_r <= cfg_data[4:0];
        pqs_pkg::REG_HIGH_CAP: hcap_r <= cfg_data[4:0];
        pqs_pkg::REG_NORM_CAP: ncap_r <= cfg_data[5:0];
        pqs_pkg::REG_RATE:     rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input word
  logic [2:0]  cmd_r;
  logic [31:0] now_r;
  logic [15:0] ref_r;
  logic [9:0]  len_r;
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_command; now_r <= in_now_ms; ref_r <= in_payload_ref; len_r <= in_payload_length;
    end
  end

  // pointers and fills
  logic [CAW-1:0] ch_r; logic [4:0] cf_r;
  logic [HAW-1:0] hh_r; logic [4:0] hf_r;
  logic [NAW-1:0] nh_r; logic [5:0] nf_r;
  logic [31:0] wstart_r;
  logic [15:0] wcnt_r;
  logic [15:0] dc_r, dh_r, dn_r;

  // effective capacities (saturate to depth)
  logic [5:0] ccap_e, hcap_e, ncap_e;
  assign ccap_e = (ccap_r > 5'(pqs_pkg::CRIT_DEPTH)) ? 6'(pqs_pkg::CRIT_DEPTH) : {1'b0, ccap_r};
  assign hcap_e = (hcap_r > 5'(pqs_pkg::HIGH_DEPTH)) ? 6'(pqs_pkg::HIGH_DEPTH) : {1'b0, hcap_r};
  assign ncap_e = (ncap_r > 6'(pqs_pkg::NORM_DEPTH)) ? 6'(pqs_pkg::NORM_DEPTH) : ncap_r;

  logic c_full, h_full, n_full, win_exp, rate_hit;
  logic [15:0] wcnt_eff;
  assign c_full = {1'b0, cf_r} >= ccap_e;
  assign h_full = {1'b0, hf_r} >= hcap_e;
  assign n_full = nf_r >= ncap_e;
  assign win_exp = (now_r - wstart_r) >= pqs_pkg::WINDOW_MS;
  assign wcnt_eff = win_exp ? 16'd0 : wcnt_r;
  assign rate_hit = wcnt_eff >= rate_r;

  // write addresses (head + fill wrapped)
  logic [CAW-1:0] cwa; logic [HAW-1:0] hwa; logic [NAW-1:0] nwa;
  assign cwa = ch_r + cf_r[CAW-1:0];
  assign hwa = hh_r + hf_r[HAW-1:0];
  assign nwa = nh_r + nf_r[NAW-1:0];

  // clipped lengths
  logic [9:0] alen, nlen;
  assign alen = (len_r > 10'(pqs_pkg::ALERT_MAX_LEN - 1)) ? 10'(pqs_pkg::ALERT_MAX_LEN - 1) : len_r;
  assign nlen = ({1'b0, len_r} > 11'(pqs_pkg::AUDIO_MAX_LEN)) ?
                10'(pqs_pkg::AUDIO_MAX_LEN) : len_r;

  logic is_c, is_h, is_n, is_d, is_clr;
  assign is_c = cmd.exec && en_r && cmd_r == pqs_pkg::CMD_ENQ_CRIT;
  assign is_h = cmd.exec && en_r && cmd_r == pqs_pkg::CMD_ENQ_HIGH;
  assign is_n = cmd.exec && en_r && cmd_r == pqs_pkg::CMD_ENQ_AUD;
  assign is_d = cmd.exec && en_r && cmd_r == pqs_pkg::CMD_DEQ;
  assign is_clr = cmd.exec && en_r && cmd_r == pqs_pkg::CMD_CLEAR;

  logic pop_c, pop_h, pop_n;
  assign pop_c = is_d && cf_r != 5'd0;
  assign pop_h = is_d && cf_r == 5'd0 && hf_r != 5'd0;
  assign pop_n = is_d && cf_r == 5'd0 && hf_r == 5'd0 && nf_r != 6'd0;

  // stores: timestamp, ref, length
  logic [57:0] cmem [pqs_pkg::CRIT_DEPTH];
  logic [57:0] hmem [pqs_pkg::HIGH_DEPTH];
  logic [57:0] nmem [pqs_pkg::NORM_DEPTH];
  logic [57:0] crd_r, hrd_r, nrd_r;

  always_ff @(posedge clk) begin
    if (is_c && !c_full) cmem[cwa] <= {now_r, ref_r, alen};
    crd_r <= cmem[ch_r];
  end
  always_ff @(posedge clk) begin
    if (is_h && !h_full) hmem[hwa] <= {now_r, ref_r, 10'd1};
    hrd_r <= hmem[hh_r];
  end
  always_ff @(posedge clk) begin
    if (is_n && !rate_hit && !n_full) nmem[nwa] <= {now_r, ref_r, nlen};
    nrd_r <= nmem[nh_r];
  end

  // exec runs as a head read followed by a commit
  logic phase_r;
  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else if (cmd.exec) phase_r <= ~phase_r;
  end
  assign stat.done = cmd.exec && phase_r;
  logic go;
  assign go = cmd.exec && phase_r;

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0; cf_r <= '0; hh_r <= '0; hf_r <= '0; nh_r <= '0; nf_r <= '0;
      wstart_r <= '0; wcnt_r <= '0; dc_r <= '0; dh_r <= '0; dn_r <= '0;
    end else if (go) begin
      if (is_c) begin
        if (c_full) begin if (dc_r != 16'hFFFF) dc_r <= dc_r + 16'd1; end
        else cf_r <= cf_r + 5'd1;
      end
      if (is_h) begin
        if (h_full) begin if (dh_r != 16'hFFFF) dh_r <= dh_r + 16'd1; end
        else hf_r <= hf_r + 5'd1;
      end
      if (is_n) begin
        if (win_exp) wstart_r <= now_r;
        if (!rate_hit) begin
          if (n_full) begin
            if (dn_r != 16'hFFFF) dn_r <= dn_r + 16'd1;
            wcnt_r <= wcnt_eff;
          end else begin
            nf_r <= nf_r + 6'd1; wcnt_r <= wcnt_eff + 16'd1;
          end
        end else wcnt_r <= wcnt_eff;
      end
      if (pop_c) begin ch_r <= ch_r + CAW'(1); cf_r <= cf_r - 5'd1; end
      if (pop_h) begin hh_r <= hh_r + HAW'(1); hf_r <= hf_r - 5'd1; end
      if (pop_n) begin nh_r <= nh_r + NAW'(1); nf_r <= nf_r - 6'd1; end
      if (is_clr) begin
        ch_r <= '0; cf_r <= '0; hh_r <= '0; hf_r <= '0; nh_r <= '0; nf_r <= '0;
      end
    end
  end

  // result word
  logic [2:0] st;
  always_comb begin
    st = pqs_pkg::ST_OK;
    if (!en_r) st = pqs_pkg::ST_DISABLED;
    else if (is_c && c_full) st = pqs_pkg::ST_FULL;
    else if (is_h && h_full) st = pqs_pkg::ST_FULL;
    else if (is_n && rate_hit) st = pqs_pkg::ST_RATE;
    else if (is_n && n_full) st = pqs_pkg::ST_FULL;
    else if (is_d && !pop_c && !pop_h && !pop_n) st = pqs_pkg::ST_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status <= st;
      out_class <= pop_h ? pqs_pkg::CLS_HIGH : (pop_n ? pqs_pkg::CLS_NORM : pqs_pkg::CLS_CRIT);
      if (pop_c) {out_timestamp, out_payload_ref, out_length} <= crd_r;
      else if (pop_h) {out_timestamp, out_payload_ref, out_length} <= hrd_r;
      else if (pop_n) {out_timestamp, out_payload_ref, out_length} <= nrd_r;
      else {out_timestamp, out_payload_ref, out_length} <= '0;
    end
  end

  // counts reflect committed state
  assign out_critical_count = cf_r;
  assign out_high_count = hf_r;
  assign out_normal_count = nf_r;
  assign out_dropped_critical = dc_r;
  assign out_dropped_high = dh_r;
  assign out_dropped_normal = dn_r;
  assign out_audio_sent_in_window = wcnt_r;
endmodule
`default_nettype wire
